FILE: sv/decimal_text_to_int128_defines.svh
// Assertion macros shared by the decimal text to int128 block.
// No dependencies; the including module must have clk and rst in scope.
`ifndef DECIMAL_TEXT_TO_INT128_DEFINES_SVH
`define DECIMAL_TEXT_TO_INT128_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DTTI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define DTTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/dtti_pkg.sv
// Shared types and constants for the decimal text to int128 block.
// No dependencies.
package dtti_pkg;

  // width of the accumulated signed value, 16 to 128
  localparam int VALUE_BITS  = 128;
  // width of the result as delivered on the ports
  localparam int RESULT_BITS = 128;
  localparam int HALF_BITS   = 64;
  // queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // no_digit_mode register codes
  localparam logic [1:0] MODE_SYNTAX = 2'd0;
  localparam logic [1:0] MODE_ZERO   = 2'd1;

  // character bytes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [2:0] {
    CLS_WS,
    CLS_DIGIT,
    CLS_MINUS,
    CLS_PLUS,
    CLS_OTHER,
    CLS_END
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
  } token_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_FIRST,
    PH_DIGITS,
    PH_TRAIL,
    PH_ZERO
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SYNTAX,
    ST_RANGE
  } status_t;

endpackage

FILE: sv/decimal_text_to_int128.sv
// Decimal text to signed 128-bit integer, one character item per cycle.
// Input channel: in_valid/in_ready carry char_code and is_end; a string is a
// run of character items closed by one item with is_end high.
// Output channel: out_valid/out_ready carry value_high, value_low and status
// (0 ok, 1 invalid syntax, 2 out of range; value zero on any error).
// One result per terminator; character items give no result.
// Config: cfg_we/cfg_wdata write no_digit_mode; the user must do so only while
// idle, which the block itself leaves unchecked. Throughput: one item per cycle
// while results are taken; the front classifies a byte and writes a two-entry
// queue, the back runs the scan step and the x10 add. A terminator passes
// through the queue and then the result register before out_valid rises.
// Stall: the result register holds until taken; characters keep flowing
// behind a waiting terminator until the queue fills, then in_ready drops.
// Reset: synchronous rst empties the queue, drops out_valid, clears the scan
// state and sets no_digit_mode to 0. After each terminator the scan state
// clears and the next character starts a new string.
// Depends on dtti_pkg, dtti_front, dtti_queue, dtti_back and the defines header.
`include "decimal_text_to_int128_defines.svh"

module decimal_text_to_int128
  import dtti_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  char_code,
  input  logic                        is_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [HALF_BITS-1:0] value_high,
  output logic [HALF_BITS-1:0]        value_low,
  output logic [1:0]                  status
);

  logic   q_full;
  logic   push;
  token_t push_token;
  logic   pop;
  logic   head_valid;
  token_t head;

  // classify and push
  dtti_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .is_end    (is_end),
    .q_full    (q_full),
    .push      (push),
    .token     (push_token)
  );

  // decoupling queue
  dtti_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_token),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // scan, accumulate, deliver
  dtti_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .value_high (value_high),
    .value_low  (value_low),
    .status     (status)
  );

  // checks
  `DTTI_ASSERT_SAME(a_err_zero, out_valid && status != ST_OK, value_high == '0 && value_low == '0, "error result carries a nonzero value")
  `DTTI_ASSERT_NEXT(a_end_gives_result, pop && head.cls == CLS_END, out_valid, "terminator taken without a result")
  `DTTI_ASSERT_SAME(a_result_from_end, $rose(out_valid), $past(pop && head.cls == CLS_END), "result appeared without a terminator")

endmodule

FILE: sv/dtti_front.sv
// Front end: input handshake and character classification.
// Depends on dtti_pkg; feeds dtti_queue.
module dtti_front
  import dtti_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       is_end,
  input  logic       q_full,
  output logic       push,
  output token_t     token
);

  logic [7:0] diff;

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign diff     = char_code - CH_ZERO;

  // classify the byte
  always_comb begin
    token.digit = diff[3:0];
    if (is_end) begin
      token.cls = CLS_END;
    end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      token.cls = CLS_DIGIT;
    end else if (char_code == CH_SPACE || (char_code >= CH_TAB && char_code <= CH_CR)) begin
      token.cls = CLS_WS;
    end else if (char_code == CH_MINUS) begin
      token.cls = CLS_MINUS;
    end else if (char_code == CH_PLUS) begin
      token.cls = CLS_PLUS;
    end else begin
      token.cls = CLS_OTHER;
    end
  end

endmodule

FILE: sv/dtti_queue.sv
// Short token queue between front and back ends.
// Depends on dtti_pkg for token_t and the queue depth.
module dtti_queue
  import dtti_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output token_t head
);

  token_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/dtti_back.sv
// Back end: scan state machine, decimal accumulator and result register.
// Depends on dtti_pkg; takes tokens from dtti_queue.
module dtti_back
  import dtti_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_wdata,
  input  logic                        head_valid,
  input  token_t                      head,
  output logic                        pop,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic signed [HALF_BITS-1:0] value_high,
  output logic [HALF_BITS-1:0]        value_low,
  output logic [1:0]                  status
);

  localparam int ACC_W = VALUE_BITS + 4;
  localparam logic [ACC_W-1:0] LIMIT = ACC_W'(1) << (VALUE_BITS - 1);

  logic [1:0]                   mode;
  phase_t                       phase, phase_next;
  status_t                      err, err_next;
  logic                         minus, minus_next;
  logic [VALUE_BITS-1:0]        mag, mag_next;
  logic [ACC_W-1:0]             mag_ext;
  logic [ACC_W-1:0]             times_ten;
  logic                         tok_end, tok_ws, tok_dig;
  logic                         go_first, go_digits, go_trail;
  logic                         end_pop;
  logic signed [VALUE_BITS-1:0] val_s;
  logic [RESULT_BITS-1:0]       val_ext;
  status_t                      res_status;
  logic [RESULT_BITS-1:0]       res_value;

  assign tok_end = head.cls == CLS_END;
  assign tok_ws  = head.cls == CLS_WS;
  assign tok_dig = head.cls == CLS_DIGIT;

  // a terminator waits until the result register is free
  assign pop     = head_valid && (!tok_end || !out_valid || out_ready);
  assign end_pop = pop && tok_end;

  // magnitude * 10 + digit, shift and add
  assign mag_ext   = ACC_W'(mag);
  assign times_ten = (mag_ext << 3) + (mag_ext << 1) + ACC_W'(head.digit);

  // scan step for the token at the head
  always_comb begin
    phase_next = phase;
    err_next   = err;
    minus_next = minus;
    mag_next   = mag;
    go_first   = 1'b0;
    go_digits  = 1'b0;
    go_trail   = 1'b0;
    if (pop && err == ST_OK && phase != PH_ZERO) begin
      case (phase)
        PH_LEAD: begin
          if (head.cls == CLS_MINUS) begin
            minus_next = 1'b1;
            phase_next = PH_FIRST;
          end else if (head.cls == CLS_PLUS) begin
            phase_next = PH_FIRST;
          end else if (!tok_ws) begin
            go_first = 1'b1;
          end
        end
        PH_FIRST:  go_first = 1'b1;
        PH_DIGITS: begin
          if (tok_dig) begin
            go_digits = 1'b1;
          end else begin
            go_trail = 1'b1;
          end
        end
        PH_TRAIL:  go_trail = 1'b1;
        default:   ;
      endcase
      // first character after whitespace and sign
      if (go_first) begin
        if (tok_dig) begin
          go_digits = 1'b1;
        end else if (mode == MODE_SYNTAX) begin
          err_next = ST_SYNTAX;
        end else if (mode == MODE_ZERO) begin
          phase_next = PH_ZERO;
        end else begin
          go_trail = 1'b1;
        end
      end
      // accumulate with range check
      if (go_digits) begin
        phase_next = PH_DIGITS;
        if (times_ten > LIMIT) begin
          err_next = ST_RANGE;
        end else begin
          mag_next = times_ten[VALUE_BITS-1:0];
        end
      end
      // only whitespace may follow the digits
      if (go_trail) begin
        phase_next = PH_TRAIL;
        if (!(tok_ws || tok_end)) begin
          err_next = ST_SYNTAX;
        end
      end
    end
  end

  // final value and status on a terminator
  assign val_s   = minus ? -mag : mag;
  assign val_ext = RESULT_BITS'(val_s);

  always_comb begin
    res_status = err_next;
    res_value  = '0;
    if (err_next == ST_OK && phase_next != PH_ZERO) begin
      if (!minus && mag == LIMIT[VALUE_BITS-1:0]) begin
        res_status = ST_RANGE;
      end else begin
        res_value = val_ext;
      end
    end
  end

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SYNTAX;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // scan state, cleared after each terminator
  always_ff @(posedge clk) begin
    if (rst || end_pop) begin
      phase <= PH_LEAD;
      err   <= ST_OK;
      minus <= 1'b0;
      mag   <= '0;
    end else begin
      phase <= phase_next;
      err   <= err_next;
      minus <= minus_next;
      mag   <= mag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (end_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_pop) begin
      value_high <= res_value[RESULT_BITS-1:HALF_BITS];
      value_low  <= res_value[HALF_BITS-1:0];
      status     <= res_status;
    end
  end

endmodule
